// ===== rtl/ffsa_pkg.sv =====
`timescale 1ns / 1ps

package ffsa_pkg;

    // Pool geometry.
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int ID_W       = 8;
    localparam int FIELD_W    = 8;

    // The free bitmap is held as words of WORD_W slots with one summary bit per word.
    localparam int WORD_W      = 16;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int WORD_COUNT  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // The id table covers every id that can name a slot.
    localparam int MAP_DEPTH  = (SLOT_COUNT < (1 << ID_W)) ? SLOT_COUNT : (1 << ID_W);
    localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);

    // Command codes.
    localparam logic [1:0] CMD_STORE  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Request from the control sequencer to the free bitmap.
    typedef struct packed {
        logic              alloc;
        logic              give_back;
        logic [SLOT_W-1:0] slot;
    } fm_req_t;

    // Response and status from the free bitmap.
    typedef struct packed {
        logic              done;
        logic              any_free;
        logic [SLOT_W-1:0] slot;
    } fm_rsp_t;

    // Index of the lowest set bit of a bitmap word.
    function automatic logic [BIT_IDX_W-1:0] first_bit(input logic [WORD_W-1:0] word);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (word[b])
            begin
                idx = BIT_IDX_W'(b);
            end
        end
        return idx;
    endfunction

    // Index of the lowest word that still holds a free slot.
    function automatic logic [WORD_IDX_W-1:0] first_word(input logic [WORD_COUNT-1:0] sum);
        logic [WORD_IDX_W-1:0] idx;
        idx = '0;
        for (int w = WORD_COUNT - 1; w >= 0; w--)
        begin
            if (sum[w])
            begin
                idx = WORD_IDX_W'(w);
            end
        end
        return idx;
    endfunction

    // Bits of a word that stand for real slots.
    function automatic logic [WORD_W-1:0] word_mask(input logic [WORD_IDX_W-1:0] widx);
        logic [WORD_W-1:0] mask;
        for (int b = 0; b < WORD_W; b++)
        begin
            mask[b] = ((int'(widx) * WORD_W + b) < SLOT_COUNT);
        end
        return mask;
    endfunction

    // Slot number from word and bit position.
    function automatic logic [SLOT_W-1:0] make_slot(input logic [WORD_IDX_W-1:0] widx,
                                                    input logic [BIT_IDX_W-1:0] bidx);
        int s;
        s = int'(widx) * WORD_W + int'(bidx);
        return SLOT_W'(s);
    endfunction

    function automatic logic [WORD_IDX_W-1:0] slot_word(input logic [SLOT_W-1:0] s);
        return WORD_IDX_W'(int'(s) / WORD_W);
    endfunction

    function automatic logic [BIT_IDX_W-1:0] slot_bit(input logic [SLOT_W-1:0] s);
        return BIT_IDX_W'(int'(s) % WORD_W);
    endfunction

    // Low bits of a slot number as carried on the result field.
    function automatic logic [FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
        logic [31:0] wide;
        wide = 32'(s);
        return wide[FIELD_W-1:0];
    endfunction

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return (int'(id) < SLOT_COUNT);
    endfunction

    function automatic logic [MAP_ADDR_W-1:0] map_addr(input logic [ID_W-1:0] id);
        return MAP_ADDR_W'(id);
    endfunction

endpackage

// ===== rtl/ffsa_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read port.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ffsa_free_map.sv =====
`timescale 1ns / 1ps

// Free bitmap: words in RAM, one summary bit per word in flip-flops.
// Each operation reads one word and writes it back in the following cycle.
module ffsa_free_map (
    input  logic              clk,
    input  logic              rst_n,
    input  ffsa_pkg::fm_req_t req,
    output ffsa_pkg::fm_rsp_t rsp
);

    typedef enum logic {FM_IDLE, FM_UPDATE} fm_state_t;

    fm_state_t                          state_reg, state_next;
    logic                               op_alloc_reg, op_alloc_next;
    logic [ffsa_pkg::WORD_IDX_W-1:0]    widx_reg, widx_next;
    logic [ffsa_pkg::BIT_IDX_W-1:0]     bidx_reg, bidx_next;
    logic [ffsa_pkg::WORD_COUNT-1:0]    summary_reg, summary_next;
    logic [ffsa_pkg::WORD_COUNT-1:0]    row_valid_reg, row_valid_next;

    logic                               ram_we;
    logic [ffsa_pkg::WORD_W-1:0]        ram_rdata;
    logic [ffsa_pkg::WORD_W-1:0]        word_cur;
    logic [ffsa_pkg::WORD_W-1:0]        word_new;
    logic [ffsa_pkg::WORD_W-1:0]        bit_sel;
    logic [ffsa_pkg::BIT_IDX_W-1:0]     bidx_use;
    logic [ffsa_pkg::WORD_IDX_W-1:0]    raddr;

    ffsa_ram #(
        .WIDTH (ffsa_pkg::WORD_W),
        .DEPTH (ffsa_pkg::WORD_COUNT)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (word_new),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Word to read: the first word with a free slot for an allocation,
    // or the word that holds the returned slot.
    always_comb
    begin
        if (req.alloc)
        begin
            raddr = ffsa_pkg::first_word(summary_reg);
        end
        else
        begin
            raddr = ffsa_pkg::slot_word(req.slot);
        end
    end

    // A word never written since reset reads as all free; padding bits never count.
    always_comb
    begin
        if (row_valid_reg[widx_reg])
        begin
            word_cur = ram_rdata & ffsa_pkg::word_mask(widx_reg);
        end
        else
        begin
            word_cur = ffsa_pkg::word_mask(widx_reg);
        end
    end

    // Modify the word: clear the lowest free bit, or set the returned one.
    always_comb
    begin
        bidx_use = op_alloc_reg ? ffsa_pkg::first_bit(word_cur) : bidx_reg;
        bit_sel  = '0;
        bit_sel[bidx_use] = 1'b1;
        if (op_alloc_reg)
        begin
            word_new = word_cur & ~bit_sel;
        end
        else
        begin
            word_new = word_cur | bit_sel;
        end
    end

    assign ram_we       = (state_reg == FM_UPDATE);
    assign rsp.done     = (state_reg == FM_UPDATE);
    assign rsp.any_free = |summary_reg;
    assign rsp.slot     = ffsa_pkg::make_slot(widx_reg, bidx_use);

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        op_alloc_next  = op_alloc_reg;
        widx_next      = widx_reg;
        bidx_next      = bidx_reg;
        summary_next   = summary_reg;
        row_valid_next = row_valid_reg;
        case (state_reg)
            FM_IDLE:
            begin
                if (req.alloc || req.give_back)
                begin
                    state_next    = FM_UPDATE;
                    op_alloc_next = req.alloc;
                    widx_next     = raddr;
                    bidx_next     = ffsa_pkg::slot_bit(req.slot);
                end
            end
            FM_UPDATE:
            begin
                state_next                = FM_IDLE;
                row_valid_next[widx_reg]  = 1'b1;
                summary_next[widx_reg]    = |word_new;
            end
            default:
            begin
                state_next = FM_IDLE;
            end
        endcase
    end

    // State and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FM_IDLE;
            op_alloc_reg  <= 1'b0;
            widx_reg      <= '0;
            bidx_reg      <= '0;
            summary_reg   <= '1;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_alloc_reg  <= op_alloc_next;
            widx_reg      <= widx_next;
            bidx_reg      <= bidx_next;
            summary_reg   <= summary_next;
            row_valid_reg <= row_valid_next;
        end
    end

endmodule

// ===== rtl/first_free_slot_allocator_with_remap.sv =====
`timescale 1ns / 1ps

// Channel  Handshake           Fields                           Direction
// in       in_valid, in_stall  command[1:0], object_id[7:0]     into the block
// out      out_valid, out_stall slot[7:0], status[1:0]          out of the block
//
// One item is in work at a time. A store does a bitmap word read, then the
// write-back; a lookup does an id table read; a remove does an id table
// read, then a bitmap word read and write-back; an item flagged at once skips these.
// After reset every slot is free and every id unmapped at once: valid bits in
// flip-flops stand in for the RAM contents, so there is no clearing pass.
// A stalled result is held in a result register; a new item waits for it.
module first_free_slot_allocator_with_remap (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] object_id,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] slot,
    output logic [1:0] status
);

    typedef enum logic [1:0] {S_IDLE, S_MAP_RD, S_FREE_WAIT, S_RESULT} state_t;

    state_t                              state_reg, state_next;
    logic [1:0]                          cmd_reg, cmd_next;
    logic [ffsa_pkg::MAP_ADDR_W-1:0]     id_reg, id_next;
    logic [ffsa_pkg::MAP_DEPTH-1:0]      map_valid_reg, map_valid_next;
    logic                                out_valid_reg, out_valid_next;
    logic [ffsa_pkg::FIELD_W-1:0]        out_slot_reg, out_slot_next;
    logic [1:0]                          out_status_reg, out_status_next;
    logic [ffsa_pkg::FIELD_W-1:0]        res_slot_reg, res_slot_next;
    logic [1:0]                          res_status_reg, res_status_next;

    logic                                accept;
    logic                                out_free;
    logic                                have_res;
    logic [ffsa_pkg::FIELD_W-1:0]        res_slot;
    logic [1:0]                          res_status;
    logic [ffsa_pkg::MAP_ADDR_W-1:0]     in_addr;
    logic                                map_we;
    logic [ffsa_pkg::SLOT_W-1:0]         map_rdata;
    ffsa_pkg::fm_req_t                   fm_req;
    ffsa_pkg::fm_rsp_t                   fm_rsp;

    assign in_addr  = ffsa_pkg::map_addr(object_id);
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Id-to-slot table; its valid bits live in map_valid_reg.
    ffsa_ram #(
        .WIDTH (ffsa_pkg::SLOT_W),
        .DEPTH (ffsa_pkg::MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (id_reg),
        .wdata (fm_rsp.slot),
        .raddr (in_addr),
        .rdata (map_rdata)
    );

    ffsa_free_map u_free_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fm_req),
        .rsp   (fm_rsp)
    );

    // Requests to the free bitmap: allocate on a store, return a slot on a remove.
    always_comb
    begin
        fm_req.alloc     = accept && (command == ffsa_pkg::CMD_STORE)
                           && ffsa_pkg::id_in_range(object_id) && fm_rsp.any_free;
        fm_req.give_back = (state_reg == S_MAP_RD) && (cmd_reg == ffsa_pkg::CMD_REMOVE);
        fm_req.slot      = map_rdata;
    end

    assign map_we = (state_reg == S_FREE_WAIT) && fm_rsp.done
                    && (cmd_reg == ffsa_pkg::CMD_STORE);

    // Sequencer: decode, table access and result hand-over.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        map_valid_next  = map_valid_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        have_res        = 1'b0;
        res_slot        = '0;
        res_status      = ffsa_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    id_next  = in_addr;
                    if (command != ffsa_pkg::CMD_STORE && command != ffsa_pkg::CMD_REMOVE
                        && command != ffsa_pkg::CMD_LOOKUP)
                    begin
                        have_res = 1'b1;
                    end
                    else if (!ffsa_pkg::id_in_range(object_id))
                    begin
                        have_res   = 1'b1;
                        res_status = ffsa_pkg::ST_RANGE;
                    end
                    else if (command == ffsa_pkg::CMD_STORE)
                    begin
                        if (fm_rsp.any_free)
                        begin
                            state_next = S_FREE_WAIT;
                        end
                        else
                        begin
                            have_res   = 1'b1;
                            res_status = ffsa_pkg::ST_FULL;
                        end
                    end
                    else if (map_valid_reg[in_addr])
                    begin
                        state_next = S_MAP_RD;
                    end
                    else
                    begin
                        have_res   = 1'b1;
                        res_status = ffsa_pkg::ST_UNMAPPED;
                    end
                end
            end
            S_MAP_RD:
            begin
                if (cmd_reg == ffsa_pkg::CMD_REMOVE)
                begin
                    map_valid_next[id_reg] = 1'b0;
                    state_next             = S_FREE_WAIT;
                end
                else
                begin
                    have_res = 1'b1;
                    res_slot = ffsa_pkg::slot_field(map_rdata);
                end
            end
            S_FREE_WAIT:
            begin
                if (fm_rsp.done)
                begin
                    have_res = 1'b1;
                    res_slot = ffsa_pkg::slot_field(fm_rsp.slot);
                    if (cmd_reg == ffsa_pkg::CMD_STORE)
                    begin
                        map_valid_next[id_reg] = 1'b1;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes to the output register, or waits if that is held.
        if (have_res)
        begin
            if (out_free)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                state_next      = S_RESULT;
                res_slot_next   = res_slot;
                res_status_next = res_status;
            end
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        if (have_res && out_free)
        begin
            out_valid_next  = 1'b1;
            out_slot_next   = res_slot;
            out_status_next = res_status;
        end
        else if (state_reg == S_RESULT && out_free)
        begin
            out_valid_next  = 1'b1;
            out_slot_next   = res_slot_reg;
            out_status_next = res_status_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= ffsa_pkg::CMD_STORE;
            id_reg         <= '0;
            map_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_status_reg <= ffsa_pkg::ST_OK;
            res_slot_reg   <= '0;
            res_status_reg <= ffsa_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            id_reg         <= id_next;
            map_valid_reg  <= map_valid_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot      = out_slot_reg;
    assign status    = out_status_reg;

    // The bitmap answers every request in the following cycle.
    a_fm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (fm_req.alloc || fm_req.give_back) |=> fm_rsp.done)
        else $error("free bitmap did not complete a request in one cycle");

    // The bitmap only finishes work that the sequencer is waiting for.
    a_fm_owner: assert property (@(posedge clk) disable iff (!rst_n)
        fm_rsp.done |-> (state_reg == S_FREE_WAIT))
        else $error("free bitmap finished outside a wait");

    // An allocation is only requested while some slot is free.
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        fm_req.alloc |-> fm_rsp.any_free)
        else $error("allocation requested from a full pool");

    // A held result never coexists with an empty output register.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) |-> out_valid_reg)
        else $error("result held while the output register was empty");

endmodule
